// File: hdl/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int unsigned HEADER_LEN        = 8;
  localparam int unsigned COUNT_BITS_DEF    = 24;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;
  localparam int unsigned CFG_IDX_W         = 8;
  localparam int unsigned CFG_DATA_W        = 24;
  localparam int unsigned MAX_PAYLOAD_W     = 24;
  localparam int unsigned HDR_STORE_W       = 8 * (HEADER_LEN - 1);
  localparam int unsigned HDR_CNT_W         = $clog2(HEADER_LEN);

  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 24'(10 * 1024 * 1024);
  localparam logic [7:0]               VERSION_RST     = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 8'd3;

  typedef enum logic [2:0] {
    ST_DATA        = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TOO_LARGE   = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] payload_byte;
    logic [7:0] message_type;
    logic       last_of_message;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Byte-stream parser for frames with an 8-byte header and a length prefix.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle with no gaps of its own making: every step
// is a byte shift, a set of header compares or a length decrement in the
// front end, and each result is registered in a queue entry and then in the
// output register. A four-entry queue parts the front end from the output
// register, so input keeps flowing while a result waits; input stalls only
// when that queue is full. After a bad header the block reports one error
// beat and then takes and drops every byte until reset. Configuration is
// written through the cfg channel, which is always ready.
module length_prefixed_frame_parser #(
  parameter int unsigned COUNT_BITS  = fpp_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = fpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] byte_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] payload_byte
  output logic [15:0]                    m_axis_tuser,   // [2:0] status, [10:3] message_type
  output logic                           m_axis_tlast,   // last_of_message
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fpp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fpp_pkg::entry_t  push_entry, head_entry;
  fpp_pkg::q_stat_t q_stat;
  logic             push, pop;

  assign cfg_ready_o = 1'b1;

  fpp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  fpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  fpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full))
    else $error("queue push while full");

  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready &&
     (m_axis_tuser[2:0] == fpp_pkg::ST_BAD_MAGIC ||
      m_axis_tuser[2:0] == fpp_pkg::ST_BAD_VERSION ||
      m_axis_tuser[2:0] == fpp_pkg::ST_TOO_LARGE))
    |-> (q_stat.empty && !push))
    else $error("result queued after an error beat");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
    (m_axis_tuser[2:0] == fpp_pkg::ST_DATA || m_axis_tuser[2:0] == fpp_pkg::ST_EMPTY))
    else $error("tlast on an error beat");

endmodule

// File: hdl/fpp_front.sv
// ----------------------------------------------------------------------------
// fpp_front
// Header collection, header checks, payload length tracking and the
// configuration registers; emits one queue entry per result-bearing byte.
// ----------------------------------------------------------------------------
module fpp_front #(
  parameter int unsigned COUNT_BITS = fpp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            byte_valid_i,
  output logic                            byte_ready_o,
  input  logic [7:0]                      byte_i,
  input  logic                            cfg_valid_i,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  fpp_pkg::q_stat_t                q_stat_i,
  output logic                            push_o,
  output fpp_pkg::entry_t                 entry_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_e;

  localparam logic [32:0] CNT_MAX = 33'((34'(1) << COUNT_BITS) - 34'(1));
  localparam logic [fpp_pkg::HDR_CNT_W-1:0] HDR_LAST =
    fpp_pkg::HDR_CNT_W'(fpp_pkg::HEADER_LEN - 1);

  phase_e                           phase_q, phase_d;
  logic [fpp_pkg::HDR_CNT_W-1:0]    hcnt_q, hcnt_d;
  logic [fpp_pkg::HDR_STORE_W-1:0]  hbytes_q, hbytes_d;
  logic [7:0]                       ctype_q, ctype_d;
  logic [COUNT_BITS-1:0]            remain_q, remain_d;

  logic [7:0]                         magic0_q, magic1_q, version_q;
  logic [fpp_pkg::MAX_PAYLOAD_W-1:0]  maxlen_q;

  logic        accept;
  logic [7:0]  h_b0, h_b1, h_b2, h_type;
  logic [31:0] h_len;
  logic        remain_last;

  assign byte_ready_o = !q_stat_i.full;
  assign accept       = byte_valid_i && byte_ready_o;

  assign h_b0        = hbytes_q[fpp_pkg::HDR_STORE_W-1 -: 8];
  assign h_b1        = hbytes_q[fpp_pkg::HDR_STORE_W-9 -: 8];
  assign h_b2        = hbytes_q[fpp_pkg::HDR_STORE_W-17 -: 8];
  assign h_type      = hbytes_q[31:24];
  assign h_len       = {hbytes_q[23:0], byte_i};
  assign remain_last = (remain_q <= COUNT_BITS'(1));

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    hbytes_d = hbytes_q;
    ctype_d  = ctype_q;
    remain_d = remain_q;
    push_o   = 1'b0;
    entry_o  = '{status: fpp_pkg::ST_DATA, payload_byte: 8'd0,
                 message_type: ctype_q, last_of_message: 1'b0};
    if (accept) begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          push_o                  = 1'b1;
          entry_o.payload_byte    = byte_i;
          entry_o.last_of_message = remain_last;
          if (remain_last) begin
            remain_d = '0;
            phase_d  = PH_HEADER;
          end else begin
            remain_d = remain_q - COUNT_BITS'(1);
          end
        end
        PH_HEADER: begin
          if (hcnt_q != HDR_LAST) begin
            hbytes_d = {hbytes_q[fpp_pkg::HDR_STORE_W-9:0], byte_i};
            hcnt_d   = hcnt_q + fpp_pkg::HDR_CNT_W'(1);
          end else begin
            hcnt_d               = '0;
            hbytes_d             = '0;
            entry_o.message_type = h_type;
            push_o               = 1'b1;
            priority if (h_b0 != magic0_q || h_b1 != magic1_q) begin
              entry_o.status = fpp_pkg::ST_BAD_MAGIC;
              phase_d        = PH_HALT;
            end else if (h_b2 != version_q) begin
              entry_o.status = fpp_pkg::ST_BAD_VERSION;
              phase_d        = PH_HALT;
            end else if (({1'b0, h_len} > {9'd0, maxlen_q}) ||
                         ({1'b0, h_len} > CNT_MAX)) begin
              entry_o.status = fpp_pkg::ST_TOO_LARGE;
              phase_d        = PH_HALT;
            end else if (h_len == 32'd0) begin
              ctype_d                 = h_type;
              entry_o.status          = fpp_pkg::ST_EMPTY;
              entry_o.last_of_message = 1'b1;
            end else begin
              ctype_d  = h_type;
              push_o   = 1'b0;
              remain_d = h_len[COUNT_BITS-1:0];
              phase_d  = PH_PAYLOAD;
            end
          end
        end
        PH_HALT: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hcnt_q   <= '0;
      hbytes_q <= '0;
      ctype_q  <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      hbytes_q <= hbytes_d;
      ctype_q  <= ctype_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic0_q  <= 8'd0;
      magic1_q  <= 8'd0;
      version_q <= fpp_pkg::VERSION_RST;
      maxlen_q  <= fpp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fpp_pkg::CFG_MAGIC_FIRST)  magic0_q  <= cfg_data_i[7:0];
      if (cfg_index_i == fpp_pkg::CFG_MAGIC_SECOND) magic1_q  <= cfg_data_i[7:0];
      if (cfg_index_i == fpp_pkg::CFG_VERSION)      version_q <= cfg_data_i[7:0];
      if (cfg_index_i == fpp_pkg::CFG_MAX_PAYLOAD) begin
        maxlen_q <= cfg_data_i[fpp_pkg::MAX_PAYLOAD_W-1:0];
      end
    end
  end

endmodule

// File: hdl/fpp_queue.sv
// ----------------------------------------------------------------------------
// fpp_queue
// Short register queue between the header front end and the output stage.
// ----------------------------------------------------------------------------
module fpp_queue #(
  parameter int unsigned DEPTH = fpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpp_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output fpp_pkg::entry_t  entry_o,
  output fpp_pkg::q_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  fpp_pkg::entry_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign entry_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

endmodule

// File: hdl/fpp_back.sv
// ----------------------------------------------------------------------------
// fpp_back
// Output register stage: drain the queue and present results as stream beats.
// ----------------------------------------------------------------------------
module fpp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpp_pkg::entry_t  entry_i,
  input  fpp_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_data_o,
  output logic [15:0]      out_user_o,
  output logic             out_last_o
);

  fpp_pkg::entry_t out_q;
  logic            valid_q, valid_d;

  assign pop_o = !q_stat_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= entry_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q.payload_byte;
  assign out_user_o  = {5'd0, out_q.message_type, out_q.status};
  assign out_last_o  = out_q.last_of_message;

endmodule
